// File: hdl/i2cm_pkg.sv
// shared types and codes for the i2c register access master
// no dependencies; compiled first

package i2cm_pkg;

  // command codes on the op field
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes (paddr[2])
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_POLL    = 1'b1;

  // configuration reset values
  localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
  localparam logic [7:0]  ACK_POLL_RST    = 8'd250;

  // bus sequencing phases
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START1    = 5'd1,
    PH_START2    = 5'd2,
    PH_START3    = 5'd3,
    PH_BIT_LOW   = 5'd4,
    PH_BIT_HIGH  = 5'd5,
    PH_ACK_LOW   = 5'd6,
    PH_ACK_HIGH  = 5'd7,
    PH_ACK_TAIL  = 5'd8,
    PH_RD_LOW    = 5'd9,
    PH_RD_HIGH   = 5'd10,
    PH_NACK_LOW  = 5'd11,
    PH_NACK_HIGH = 5'd12,
    PH_STOP1     = 5'd13,
    PH_STOP2     = 5'd14,
    PH_STOP3     = 5'd15,
    PH_DONE      = 5'd16
  } phase_t;

  // one tick request as seen by the sequencer
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } tick_req_t;

  // line levels and status for one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] rd_data;
  } tick_res_t;

  // configuration register contents
  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

endpackage

// File: hdl/i2cm_in_if.sv
// request channel: valid/ready plus one tick of command and sda sample
// no dependencies

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic       sda_in;

  modport source (output valid, op, dev_addr, reg_addr, wr_data, sda_in, input ready);
  modport sink   (input valid, op, dev_addr, reg_addr, wr_data, sda_in, output ready);
endinterface

// File: hdl/i2cm_out_if.sv
// result channel: valid/ready plus line levels and status of one tick
// no dependencies

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_error;
  logic [7:0] rd_data;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, ack_error,
                  rd_data, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, ack_error,
                  rd_data, output ready);
endinterface

// File: hdl/i2c_master_register_access.sv
// top level of the i2c register access master: request/result channels,
// apb configuration registers and result register
// depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_seq
//
//   channel   direction  handshake      carries
//   in_ch     sink       valid/ready    op, dev_addr, reg_addr, wr_data, sda_in
//   out_ch    source     valid/ready    scl, sda pull, busy, done, ack error, rd_data
//   cfg       apb slave  psel/penable   phase_ticks (0x0), ack_poll_limit (0x4)
//
// one request is one bus tick; a request is taken every cycle unless the
// result register is stalled, and its result is in the result register the next cycle
// the sequencer state and the result register are the only stages in the path
// a stalled result register holds and blocks new requests until taken
// synchronous active-low reset returns to idle with default configuration

module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg_r;
  tick_req_t req;
  tick_res_t seq_res;
  tick_res_t res_r;
  logic      out_valid_r;
  logic      accept;
  logic      cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks    <= PHASE_TICKS_RST;
      cfg_r.ack_poll_limit <= ACK_POLL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PHASE_TICKS: cfg_r.phase_ticks    <= pwdata[15:0];
        REG_ACK_POLL:    cfg_r.ack_poll_limit <= pwdata[7:0];
        default:         cfg_r.phase_ticks    <= cfg_r.phase_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PHASE_TICKS: prdata = {16'd0, cfg_r.phase_ticks};
      REG_ACK_POLL:    prdata = {24'd0, cfg_r.ack_poll_limit};
      default:         prdata = 32'd0;
    endcase
  end

  // request handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign req.op       = in_ch.op;
  assign req.dev_addr = in_ch.dev_addr;
  assign req.reg_addr = in_ch.reg_addr;
  assign req.wr_data  = in_ch.wr_data;
  assign req.sda_in   = in_ch.sda_in;

  i2cm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .req   (req),
    .cfg   (cfg_r),
    .res   (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= seq_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_level    = res_r.scl_level;
  assign out_ch.sda_pull_low = res_r.sda_pull_low;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.ack_error    = res_r.ack_error;
  assign out_ch.rd_data      = res_r.rd_data;

endmodule

// File: hdl/i2cm_seq.sv
// bus sequencer: phase state machine, shift and counters, one step per tick
// depends on i2cm_pkg

module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  tick_req_t req,
  input  cfg_t      cfg,
  output tick_res_t res
);

  phase_t      phase_r,    phase_nxt;
  logic [2:0]  bit_cnt_r,  bit_cnt_nxt;
  logic [7:0]  shift_r,    shift_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [15:0] tick_r,     tick_nxt;
  logic [7:0]  poll_r,     poll_nxt;
  logic [6:0]  dev_r,      dev_nxt;
  logic [7:0]  reg_r,      reg_nxt;
  logic [7:0]  dat_r,      dat_nxt;
  logic        is_read_r,  is_read_nxt;
  logic [7:0]  rd_byte_r,  rd_byte_nxt;
  logic        err_r,      err_nxt;

  logic        busy;
  logic [15:0] len;
  logic        phase_end;

  // byte sent at each position of the transfer
  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [6:0] dev,
                                          input logic [7:0] ra, input logic [7:0] dat,
                                          input logic rd);
    logic [7:0] b;
    begin
      unique case (idx)
        2'd0:    b = {dev, 1'b0};
        2'd1:    b = ra;
        2'd2:    b = rd ? {dev, 1'b1} : dat;
        default: b = 8'd0;
      endcase
      return b;
    end
  endfunction

  // phase length and end of phase
  assign busy      = (phase_r != PH_IDLE) && (phase_r != PH_DONE);
  assign len       = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
  assign phase_end = ({1'b0, tick_r} + 17'd1) >= {1'b0, len};

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    tick_nxt     = tick_r;
    poll_nxt     = poll_r;
    dev_nxt      = dev_r;
    reg_nxt      = reg_r;
    dat_nxt      = dat_r;
    is_read_nxt  = is_read_r;
    rd_byte_nxt  = rd_byte_r;
    err_nxt      = err_r;
    if (!busy) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = 16'd0;
      if ((req.op == OP_WRITE) || (req.op == OP_READ)) begin
        dev_nxt      = req.dev_addr;
        reg_nxt      = req.reg_addr;
        dat_nxt      = req.wr_data;
        is_read_nxt  = (req.op == OP_READ);
        byte_idx_nxt = 2'd0;
        bit_cnt_nxt  = 3'd0;
        poll_nxt     = 8'd0;
        err_nxt      = 1'b0;
        phase_nxt    = PH_START1;
      end
    end else if (!phase_end) begin
      tick_nxt = tick_r + 16'd1;
    end else begin
      tick_nxt = 16'd0;
      unique case (phase_r)
        PH_START1: phase_nxt = PH_START2;
        PH_START2: phase_nxt = PH_START3;
        PH_START3: begin
          shift_nxt   = byte_for(byte_idx_r, dev_r, reg_r, dat_r, is_read_r);
          bit_cnt_nxt = 3'd0;
          phase_nxt   = PH_BIT_LOW;
        end
        PH_BIT_LOW: phase_nxt = PH_BIT_HIGH;
        PH_BIT_HIGH: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_cnt_r == 3'd7) begin
            poll_nxt  = 8'd0;
            phase_nxt = PH_ACK_LOW;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = PH_BIT_LOW;
          end
        end
        PH_ACK_LOW: phase_nxt = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          // low sda is an ack; high polls count up to the limit
          if (!req.sda_in) begin
            phase_nxt = PH_ACK_TAIL;
          end else if (poll_r >= cfg.ack_poll_limit) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_STOP1;
          end else begin
            poll_nxt = poll_r + 8'd1;
          end
        end
        PH_ACK_TAIL: begin
          if (is_read_r && (byte_idx_r == 2'd1)) begin
            // repeated start before address+read
            byte_idx_nxt = 2'd2;
            phase_nxt    = PH_START1;
          end else if (byte_idx_r[1]) begin
            if (is_read_r) begin
              bit_cnt_nxt = 3'd0;
              shift_nxt   = 8'd0;
              phase_nxt   = PH_RD_LOW;
            end else begin
              phase_nxt = PH_STOP1;
            end
          end else begin
            byte_idx_nxt = byte_idx_r + 2'd1;
            shift_nxt    = byte_for(byte_idx_r + 2'd1, dev_r, reg_r, dat_r, is_read_r);
            bit_cnt_nxt  = 3'd0;
            phase_nxt    = PH_BIT_LOW;
          end
        end
        PH_RD_LOW: phase_nxt = PH_RD_HIGH;
        PH_RD_HIGH: begin
          shift_nxt = {shift_r[6:0], req.sda_in};
          if (bit_cnt_r == 3'd7) begin
            rd_byte_nxt = {shift_r[6:0], req.sda_in};
            phase_nxt   = PH_NACK_LOW;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = PH_RD_LOW;
          end
        end
        PH_NACK_LOW:  phase_nxt = PH_NACK_HIGH;
        PH_NACK_HIGH: phase_nxt = PH_STOP1;
        PH_STOP1:     phase_nxt = PH_STOP2;
        PH_STOP2:     phase_nxt = PH_STOP3;
        PH_STOP3:     phase_nxt = PH_DONE;
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  // line levels and status from the current phase
  always_comb begin
    res.scl_level    = 1'b1;
    res.sda_pull_low = 1'b0;
    res.busy_res     = 1'b1;
    res.done_res     = 1'b0;
    res.ack_error    = 1'b0;
    res.rd_data      = rd_byte_r;
    unique case (phase_r)
      PH_START2: res.sda_pull_low = 1'b1;
      PH_START3, PH_STOP1: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
      end
      PH_BIT_LOW: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = !shift_r[7];
      end
      PH_BIT_HIGH: res.sda_pull_low = !shift_r[7];
      PH_ACK_LOW, PH_ACK_TAIL, PH_RD_LOW, PH_NACK_LOW: res.scl_level = 1'b0;
      PH_STOP2: res.sda_pull_low = 1'b1;
      PH_IDLE:  res.busy_res = 1'b0;
      PH_DONE: begin
        res.busy_res  = 1'b0;
        res.done_res  = 1'b1;
        res.ack_error = err_r;
      end
      default: res.scl_level = 1'b1;
    endcase
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 3'd0;
      shift_r    <= 8'd0;
      byte_idx_r <= 2'd0;
      tick_r     <= 16'd0;
      poll_r     <= 8'd0;
      dev_r      <= 7'd0;
      reg_r      <= 8'd0;
      dat_r      <= 8'd0;
      is_read_r  <= 1'b0;
      rd_byte_r  <= 8'd0;
      err_r      <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_idx_r <= byte_idx_nxt;
      tick_r     <= tick_nxt;
      poll_r     <= poll_nxt;
      dev_r      <= dev_nxt;
      reg_r      <= reg_nxt;
      dat_r      <= dat_nxt;
      is_read_r  <= is_read_nxt;
      rd_byte_r  <= rd_byte_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// File: sim/i2c_master_register_access_tb.sv
// self-checking bench for the i2c register access master: drives bus tick requests,
// predicts scl/sda levels and status per tick, and programs the apb registers
// depends on i2cm_pkg, i2cm_in_if, i2cm_out_if and the i2c_master_register_access rtl

module i2c_master_register_access_tb
  import i2cm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // op value with no command behind it, must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_LIMIT = 50;

  // one row of the opening directed sequence
  typedef struct {
    tick_req_t req;
    bit        fixed;
    tick_res_t want;
  } tick_row_t;

  // one stretch of the run: bus timing, ack behavior and idling
  typedef struct {
    int unsigned hold;
    int unsigned polls;
    int unsigned ticks;
    int unsigned ack_pct;
    int unsigned gap_pct;
    int unsigned stall_pct;
  } bus_plan_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_register_access uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bus sequencer shadow state
  phase_t      bus_phase  = PH_IDLE;
  logic [2:0]  bit_cnt    = '0;
  logic [7:0]  shift_reg  = '0;
  logic [1:0]  byte_sel   = '0;
  logic [15:0] hold_cnt   = '0;
  logic [7:0]  poll_cnt   = '0;
  logic [6:0]  cmd_dev    = '0;
  logic [7:0]  cmd_reg    = '0;
  logic [7:0]  cmd_data   = '0;
  logic        cmd_read   = 1'b0;
  logic [7:0]  rx_byte    = '0;
  logic        nack_seen  = 1'b0;
  logic [15:0] cfg_hold   = PHASE_TICKS_RST;
  logic [7:0]  cfg_polls  = ACK_POLL_RST;

  tick_res_t   pending_levels[$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  // opening rows: reset levels, ignored ops, field extremes, start of a write
  tick_row_t opening [16] = '{
    '{'{OP_NONE,   7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_UNUSED, 7'h7f, 8'hff, 8'hff, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_NONE,   7'h7f, 8'hff, 8'hff, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_WRITE,  7'h7f, 8'hff, 8'h00, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{'{OP_READ,   7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{OP_WRITE,  7'h55, 8'haa, 8'h5a, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{OP_NONE,   7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{OP_NONE,   7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{OP_UNUSED, 7'h2a, 8'h55, 8'haa, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{OP_READ,   7'h7f, 8'hff, 8'hff, 1'b1}, 1'b0, '0},
    '{'{OP_WRITE,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_NONE,   7'h7f, 8'h00, 8'hff, 1'b1}, 1'b0, '0},
    '{'{OP_NONE,   7'h00, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_READ,   7'h33, 8'hcc, 8'h33, 1'b1}, 1'b0, '0},
    '{'{OP_UNUSED, 7'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_NONE,   7'h7f, 8'hff, 8'hff, 1'b1}, 1'b0, '0}
  };

  // zero poll limit, zero phase ticks, slow bus, max ticks then a cut mid-phase,
  // max poll limit with no ack at all, reset poll limit with no idling
  bus_plan_t bus_plan [6] = '{
    '{1,     0,   180, 80, 15, 50},
    '{0,     2,   180, 70, 15, 50},
    '{2,     3,   220, 75, 50, 15},
    '{65535, 255, 60,  85, 50, 15},
    '{1,     255, 300, 0,  50, 15},
    '{1,     250, 200, 90, 0,  0}
  };

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mismatch reporting
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PRINT_LIMIT)
      $display("mismatch on %s at result %0d: got %0h expected %0h",
               what, results_seen, got, want);
    mismatch_cnt++;
  endtask

  // byte sent at each position of the frame
  function automatic logic [7:0] frame_byte(input logic [1:0] sel);
    case (sel)
      2'd0:    return {cmd_dev, 1'b0};
      2'd1:    return cmd_reg;
      2'd2:    return cmd_read ? {cmd_dev, 1'b1} : cmd_data;
      default: return 8'h00;
    endcase
  endfunction

  // line levels for this tick, then advance the sequencer by one tick
  function automatic tick_res_t advance_bus(input tick_req_t r);
    tick_res_t   res;
    int unsigned len;
    res = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, rx_byte};
    len = (cfg_hold == 16'd0) ? 1 : int'(cfg_hold);

    // moore outputs from the current phase
    case (bus_phase)
      PH_START2, PH_STOP2: res.sda_pull_low = 1'b1;
      PH_START3, PH_STOP1: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = 1'b1;
      end
      PH_BIT_LOW: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = ~shift_reg[7];
      end
      PH_BIT_HIGH: res.sda_pull_low = ~shift_reg[7];
      PH_ACK_LOW, PH_ACK_TAIL, PH_RD_LOW, PH_NACK_LOW: res.scl_level = 1'b0;
      PH_IDLE: res.busy_res = 1'b0;
      PH_DONE: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        res.ack_error = nack_seen;
      end
      default: ;
    endcase

    // idle or done: take a command if one is offered
    if (!res.busy_res) begin
      bus_phase = PH_IDLE;
      hold_cnt = '0;
      if (r.op == OP_WRITE || r.op == OP_READ) begin
        cmd_dev = r.dev_addr;
        cmd_reg = r.reg_addr;
        cmd_data = r.wr_data;
        cmd_read = (r.op == OP_READ);
        byte_sel = '0;
        bit_cnt = '0;
        poll_cnt = '0;
        nack_seen = 1'b0;
        bus_phase = PH_START1;
      end
      return res;
    end

    // hold the phase until its tick count runs out
    if ({16'h0, hold_cnt} + 32'd1 < len) begin
      hold_cnt = hold_cnt + 16'd1;
      return res;
    end
    hold_cnt = '0;

    // phase transitions
    case (bus_phase)
      PH_START1: bus_phase = PH_START2;
      PH_START2: bus_phase = PH_START3;
      PH_START3: begin
        shift_reg = frame_byte(byte_sel);
        bit_cnt = '0;
        bus_phase = PH_BIT_LOW;
      end
      PH_BIT_LOW: bus_phase = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        shift_reg = {shift_reg[6:0], 1'b0};
        if (bit_cnt == 3'd7) begin
          poll_cnt = '0;
          bus_phase = PH_ACK_LOW;
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          bus_phase = PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: bus_phase = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (!r.sda_in) begin
          bus_phase = PH_ACK_TAIL;
        end else if (poll_cnt >= cfg_polls) begin
          nack_seen = 1'b1;
          bus_phase = PH_STOP1;
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end
      PH_ACK_TAIL: begin
        // read turns around with a repeated start after the register byte
        if (cmd_read && byte_sel == 2'd1) begin
          byte_sel = 2'd2;
          bus_phase = PH_START1;
        end else if (byte_sel >= 2'd2) begin
          if (cmd_read) begin
            bit_cnt = '0;
            shift_reg = '0;
            bus_phase = PH_RD_LOW;
          end else begin
            bus_phase = PH_STOP1;
          end
        end else begin
          byte_sel = byte_sel + 2'd1;
          shift_reg = frame_byte(byte_sel);
          bit_cnt = '0;
          bus_phase = PH_BIT_LOW;
        end
      end
      PH_RD_LOW: bus_phase = PH_RD_HIGH;
      PH_RD_HIGH: begin
        shift_reg = {shift_reg[6:0], r.sda_in};
        if (bit_cnt == 3'd7) begin
          rx_byte = shift_reg;
          bus_phase = PH_NACK_LOW;
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          bus_phase = PH_RD_LOW;
        end
      end
      PH_NACK_LOW:  bus_phase = PH_NACK_HIGH;
      PH_NACK_HIGH: bus_phase = PH_STOP1;
      PH_STOP1:     bus_phase = PH_STOP2;
      PH_STOP2:     bus_phase = PH_STOP3;
      PH_STOP3:     bus_phase = PH_DONE;
      default:      bus_phase = PH_IDLE;
    endcase
    return res;
  endfunction

  // random tick: commands when the master can take one, ack bias at ack polls
  function automatic tick_req_t next_tick(input int unsigned ack_pct);
    tick_req_t   r;
    int unsigned pick;
    r.dev_addr = 7'($urandom);
    r.reg_addr = 8'($urandom);
    r.wr_data = 8'($urandom);
    r.sda_in = 1'($urandom_range(1));
    if (bus_phase == PH_IDLE || bus_phase == PH_DONE) begin
      pick = $urandom_range(99);
      if (pick < 42)      r.op = OP_WRITE;
      else if (pick < 84) r.op = OP_READ;
      else if (pick < 92) r.op = OP_NONE;
      else                r.op = OP_UNUSED;
    end else begin
      r.op = 2'($urandom_range(3));
    end
    if (bus_phase == PH_ACK_HIGH)
      r.sda_in = ($urandom_range(99) >= ack_pct);
    return r;
  endfunction

  // present one request, wait for it to be taken, queue its expected levels
  task automatic send_tick(input tick_req_t r, input bit fixed, input tick_res_t want);
    tick_res_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.op <= r.op;
    in_ch.dev_addr <= r.dev_addr;
    in_ch.reg_addr <= r.reg_addr;
    in_ch.wr_data <= r.wr_data;
    in_ch.sda_in <= r.sda_in;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    res = advance_bus(r);
    pending_levels.push_back(fixed ? want : res);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] mask;
    mask = (sel == REG_PHASE_TICKS) ? 32'h0000_ffff : 32'h0000_00ff;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PHASE_TICKS) cfg_hold = value[15:0];
    else                        cfg_polls = value[7:0];

    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((prdata & mask) !== (value & mask))
      report_mismatch("register read back", prdata & mask, value & mask);
  endtask

  // wait until every queued result has come back
  task automatic drain_results();
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // result side: random stall, compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    tick_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, 32'h0);
      end else begin
        want = pending_levels.pop_front();
        if (out_ch.scl_level !== want.scl_level)
          report_mismatch("scl_level", out_ch.scl_level, want.scl_level);
        if (out_ch.sda_pull_low !== want.sda_pull_low)
          report_mismatch("sda_pull_low", out_ch.sda_pull_low, want.sda_pull_low);
        if (out_ch.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_ch.busy_res, want.busy_res);
        if (out_ch.done_res !== want.done_res)
          report_mismatch("done_res", out_ch.done_res, want.done_res);
        if (out_ch.ack_error !== want.ack_error)
          report_mismatch("ack_error", out_ch.ack_error, want.ack_error);
        if (out_ch.rd_data !== want.rd_data)
          report_mismatch("rd_data", out_ch.rd_data, want.rd_data);
      end
      results_seen++;
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NONE;
    in_ch.dev_addr = '0;
    in_ch.reg_addr = '0;
    in_ch.wr_data = '0;
    in_ch.sda_in = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening at reset configuration
    gap_pct = 15;
    stall_pct = 50;
    foreach (opening[i])
      send_tick(opening[i].req, opening[i].fixed, opening[i].want);
    in_ch.valid <= 1'b0;

    // random stretches, registers changed only with the channel empty
    foreach (bus_plan[p]) begin
      drain_results();
      write_reg(REG_PHASE_TICKS, bus_plan[p].hold);
      write_reg(REG_ACK_POLL, bus_plan[p].polls);
      gap_pct = bus_plan[p].gap_pct;
      stall_pct = bus_plan[p].stall_pct;
      repeat (bus_plan[p].ticks)
        send_tick(next_tick(bus_plan[p].ack_pct), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
